@@ rtl/core/saturating_15bit_alu_defines.svh @@
// assertion macros used by the checker file
`ifndef SATURATING_15BIT_ALU_DEFINES_SVH
`define SATURATING_15BIT_ALU_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define SAT15_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define SAT15_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SAT15_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/sat15alu_pkg.sv @@
`default_nettype none

package sat15alu_pkg;

    localparam int WORD_BITS_DEFAULT = 15;
    localparam int FUNC_BITS = 7;

    localparam logic [FUNC_BITS-1:0] CMD_ADD = 7'h1E;
    localparam logic [FUNC_BITS-1:0] CMD_SUB = 7'h1F;
    localparam logic [FUNC_BITS-1:0] CMD_DIV = 7'h20;
    localparam logic [FUNC_BITS-1:0] CMD_MUL = 7'h21;

    // operation class carried down the pipeline
    localparam int KIND_BITS = 3;
    localparam logic [KIND_BITS-1:0] KIND_FAULT   = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_ADD_SUB = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_DIV     = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_MUL     = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_INVALID = 3'd4;

endpackage

`default_nettype wire

@@ rtl/core/sat15alu_if.sv @@
`default_nettype none

interface sat15alu_in_if #(
    parameter int WORD_BITS = sat15alu_pkg::WORD_BITS_DEFAULT
) ();
    logic                               valid;
    logic                               ready;
    logic [sat15alu_pkg::FUNC_BITS-1:0] func;
    logic [WORD_BITS-1:0]               acc_value;
    logic [WORD_BITS-1:0]               memory_word;
    logic                               memory_fault;

    modport source (
        output valid, func, acc_value, memory_word, memory_fault,
        input  ready
    );
    modport sink (
        input  valid, func, acc_value, memory_word, memory_fault,
        output ready
    );
endinterface

interface sat15alu_out_if #(
    parameter int WORD_BITS = sat15alu_pkg::WORD_BITS_DEFAULT
) ();
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] acc_result;
    logic                 acc_write;
    logic                 overflow_flag;
    logic                 div_zero_flag;
    logic                 mem_fault_flag;
    logic                 invalid_cmd_flag;

    modport source (
        output valid, acc_result, acc_write, overflow_flag, div_zero_flag,
               mem_fault_flag, invalid_cmd_flag,
        input  ready
    );
    modport sink (
        input  valid, acc_result, acc_write, overflow_flag, div_zero_flag,
               mem_fault_flag, invalid_cmd_flag,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/sat15alu_front.sv @@
`default_nettype none

module sat15alu_front #(
    parameter int WORD_BITS = sat15alu_pkg::WORD_BITS_DEFAULT
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    sat15alu_in_if.sink req,
    input  wire logic   down_ready,
    output logic        stage_valid,
    output logic [sat15alu_pkg::KIND_BITS + 2 + 7*WORD_BITS - 1:0] stage_data
);

    localparam int W = WORD_BITS;

    typedef struct packed {
        logic [sat15alu_pkg::KIND_BITS-1:0] kind;
        logic                               neg;
        logic                               ovf;
        logic [W-1:0]                       acc;
        logic [W-1:0]                       sum;
        logic [2*W-1:0]                     prod;
        logic [W-1:0]                       dvs;
        logic [W-1:0]                       rem;
        logic [W-1:0]                       dq;
    } stage_t;

    localparam logic [W-1:0] MAX_WORD = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MIN_WORD = {1'b1, {(W-1){1'b0}}};

    logic           valid_reg;
    logic           valid_next;
    stage_t         data_reg;
    stage_t         data_next;
    logic           take;
    logic [W-1:0]   a;
    logic [W-1:0]   b;
    logic [W-1:0]   mag_a;
    logic [W-1:0]   mag_b;
    logic           is_sub;
    logic [W-1:0]   sum_raw;
    logic           same;
    logic           ovf_as;

    assign req.ready = !valid_reg || down_ready;
    assign take      = req.valid && req.ready;

    assign a      = req.acc_value;
    assign b      = req.memory_word;
    assign mag_a  = a[W-1] ? (~a + 1'b1) : a;
    assign mag_b  = b[W-1] ? (~b + 1'b1) : b;
    assign is_sub = (req.func == sat15alu_pkg::CMD_SUB);
    assign sum_raw = is_sub ? (a - b) : (a + b);
    assign same    = is_sub ? (a[W-1] != b[W-1]) : (a[W-1] == b[W-1]);
    assign ovf_as  = same && (sum_raw[W-1] != a[W-1]);

    always_comb
    begin
        data_next.neg  = a[W-1] ^ b[W-1];
        data_next.ovf  = ovf_as;
        data_next.acc  = a;
        data_next.sum  = ovf_as ? (a[W-1] ? MIN_WORD : MAX_WORD) : sum_raw;
        data_next.prod = (2*W)'(mag_a) * (2*W)'(mag_b);
        data_next.dvs  = mag_b;
        data_next.rem  = '0;
        data_next.dq   = mag_a;
        if (req.memory_fault)
        begin
            data_next.kind = sat15alu_pkg::KIND_FAULT;
        end
        else
        begin
            case (req.func)
                sat15alu_pkg::CMD_ADD: data_next.kind = sat15alu_pkg::KIND_ADD_SUB;
                sat15alu_pkg::CMD_SUB: data_next.kind = sat15alu_pkg::KIND_ADD_SUB;
                sat15alu_pkg::CMD_DIV: data_next.kind = sat15alu_pkg::KIND_DIV;
                sat15alu_pkg::CMD_MUL: data_next.kind = sat15alu_pkg::KIND_MUL;
                default:               data_next.kind = sat15alu_pkg::KIND_INVALID;
            endcase
        end
    end

    assign valid_next = take || (valid_reg && !down_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= data_next;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_data  = data_reg;

endmodule

`default_nettype wire

@@ rtl/core/sat15alu_div_step.sv @@
`default_nettype none

module sat15alu_div_step #(
    parameter int WORD_BITS = sat15alu_pkg::WORD_BITS_DEFAULT
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic up_valid,
    input  wire logic [sat15alu_pkg::KIND_BITS + 2 + 7*WORD_BITS - 1:0] up_data,
    output logic      up_ready,
    input  wire logic down_ready,
    output logic      stage_valid,
    output logic [sat15alu_pkg::KIND_BITS + 2 + 7*WORD_BITS - 1:0] stage_data
);

    localparam int W = WORD_BITS;

    typedef struct packed {
        logic [sat15alu_pkg::KIND_BITS-1:0] kind;
        logic                               neg;
        logic                               ovf;
        logic [W-1:0]                       acc;
        logic [W-1:0]                       sum;
        logic [2*W-1:0]                     prod;
        logic [W-1:0]                       dvs;
        logic [W-1:0]                       rem;
        logic [W-1:0]                       dq;
    } stage_t;

    logic         valid_reg;
    logic         valid_next;
    stage_t       data_reg;
    stage_t       data_next;
    stage_t       cur;
    logic         take;
    logic [W:0]   trial;
    logic [W:0]   diff;
    logic         qbit;

    assign cur      = up_data;
    assign up_ready = !valid_reg || down_ready;
    assign take     = up_valid && up_ready;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {cur.rem, cur.dq[W-1]};
    assign diff  = trial - {1'b0, cur.dvs};
    assign qbit  = !diff[W];

    always_comb
    begin
        data_next     = cur;
        data_next.rem = qbit ? diff[W-1:0] : trial[W-1:0];
        data_next.dq  = {cur.dq[W-2:0], qbit};
    end

    assign valid_next = take || (valid_reg && !down_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= data_next;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_data  = data_reg;

endmodule

`default_nettype wire

@@ rtl/core/sat15alu_back.sv @@
`default_nettype none

module sat15alu_back #(
    parameter int WORD_BITS = sat15alu_pkg::WORD_BITS_DEFAULT
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      up_valid,
    input  wire logic [sat15alu_pkg::KIND_BITS + 2 + 7*WORD_BITS - 1:0] up_data,
    output logic           up_ready,
    sat15alu_out_if.source rsp
);

    localparam int W = WORD_BITS;

    typedef struct packed {
        logic [sat15alu_pkg::KIND_BITS-1:0] kind;
        logic                               neg;
        logic                               ovf;
        logic [W-1:0]                       acc;
        logic [W-1:0]                       sum;
        logic [2*W-1:0]                     prod;
        logic [W-1:0]                       dvs;
        logic [W-1:0]                       rem;
        logic [W-1:0]                       dq;
    } stage_t;

    localparam logic [W-1:0]   MAX_WORD = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]   MIN_WORD = {1'b1, {(W-1){1'b0}}};
    localparam logic [2*W-1:0] MIN_MAG  = {{(W+1){1'b0}}, {1'b1, {(W-2){1'b0}}}} << 1;
    localparam logic [2*W-1:0] MAX_MAG  = MIN_MAG - 1'b1;

    typedef struct packed {
        logic [W-1:0] acc_result;
        logic         acc_write;
        logic         overflow_flag;
        logic         div_zero_flag;
        logic         mem_fault_flag;
        logic         invalid_cmd_flag;
    } result_t;

    logic     valid_reg;
    logic     valid_next;
    result_t  res_reg;
    result_t  res_next;
    stage_t   cur;
    logic     take;
    logic     mul_sat;

    assign cur      = up_data;
    assign up_ready = !valid_reg || rsp.ready;
    assign take     = up_valid && up_ready;

    assign mul_sat = cur.neg ? (cur.prod > MIN_MAG) : (cur.prod > MAX_MAG);

    always_comb
    begin
        res_next = '0;
        res_next.acc_result = cur.acc;
        case (cur.kind)
            sat15alu_pkg::KIND_FAULT:
            begin
                res_next.mem_fault_flag = 1'b1;
            end
            sat15alu_pkg::KIND_ADD_SUB:
            begin
                res_next.acc_result    = cur.sum;
                res_next.acc_write     = 1'b1;
                res_next.overflow_flag = cur.ovf;
            end
            sat15alu_pkg::KIND_DIV:
            begin
                if (cur.dvs == '0)
                begin
                    res_next.div_zero_flag = 1'b1;
                end
                else
                begin
                    res_next.acc_result = cur.neg ? (~cur.dq + 1'b1) : cur.dq;
                    res_next.acc_write  = 1'b1;
                end
            end
            sat15alu_pkg::KIND_MUL:
            begin
                res_next.acc_write = 1'b1;
                if (mul_sat)
                begin
                    res_next.overflow_flag = 1'b1;
                    res_next.acc_result    = cur.neg ? MIN_WORD : MAX_WORD;
                end
                else
                begin
                    res_next.acc_result = cur.neg ? (~cur.prod[W-1:0] + 1'b1)
                                                  : cur.prod[W-1:0];
                end
            end
            default:
            begin
                res_next.invalid_cmd_flag = 1'b1;
            end
        endcase
    end

    assign valid_next = take || (valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    assign rsp.valid            = valid_reg;
    assign rsp.acc_result       = res_reg.acc_result;
    assign rsp.acc_write        = res_reg.acc_write;
    assign rsp.overflow_flag    = res_reg.overflow_flag;
    assign rsp.div_zero_flag    = res_reg.div_zero_flag;
    assign rsp.mem_fault_flag   = res_reg.mem_fault_flag;
    assign rsp.invalid_cmd_flag = res_reg.invalid_cmd_flag;

endmodule

`default_nettype wire

@@ rtl/core/saturating_15bit_alu.sv @@
// throughput: one item per cycle while the output is not stalled; the divider is a
// chain of WORD_BITS pipeline stages resolving one quotient bit each, and every
// operation flows through it
// each stage holds its item under back-pressure and fills bubbles independently
// reset: rst_n asynchronous active low clears all stage valid bits, payload is not reset
`default_nettype none

module saturating_15bit_alu #(
    parameter int WORD_BITS = sat15alu_pkg::WORD_BITS_DEFAULT
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    sat15alu_in_if.sink    req,
    sat15alu_out_if.source rsp
);

    localparam int W  = WORD_BITS;
    localparam int DW = sat15alu_pkg::KIND_BITS + 2 + 7*W;

    logic          stage_valid [0:W];
    logic [DW-1:0] stage_data  [0:W];
    logic          stage_ready [0:W];

    sat15alu_front #(
        .WORD_BITS (W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .down_ready  (stage_ready[0]),
        .stage_valid (stage_valid[0]),
        .stage_data  (stage_data[0])
    );

    for (genvar k = 1; k <= W; k++)
    begin : g_div
        sat15alu_div_step #(
            .WORD_BITS (W)
        ) u_step (
            .clk         (clk),
            .rst_n       (rst_n),
            .up_valid    (stage_valid[k-1]),
            .up_data     (stage_data[k-1]),
            .up_ready    (stage_ready[k-1]),
            .down_ready  (stage_ready[k]),
            .stage_valid (stage_valid[k]),
            .stage_data  (stage_data[k])
        );
    end

    sat15alu_back #(
        .WORD_BITS (W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (stage_valid[W]),
        .up_data  (stage_data[W]),
        .up_ready (stage_ready[W]),
        .rsp      (rsp)
    );

endmodule

`default_nettype wire

@@ rtl/core/sat15alu_checker.sv @@
`default_nettype none

`include "saturating_15bit_alu_defines.svh"

module sat15alu_checker #(
    parameter int WORD_BITS = sat15alu_pkg::WORD_BITS_DEFAULT
) (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_ready,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire logic [WORD_BITS-1:0] acc_result,
    input wire logic                 acc_write,
    input wire logic                 overflow_flag,
    input wire logic                 div_zero_flag,
    input wire logic                 mem_fault_flag,
    input wire logic                 invalid_cmd_flag
);

    localparam logic [WORD_BITS-1:0] MAX_WORD = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS-1:0] MIN_WORD = {1'b1, {(WORD_BITS-1){1'b0}}};

    // at most one flag per item
    `SAT15_ASSERT_IMPLIES(a_flags_onehot, out_valid, $onehot0({overflow_flag, div_zero_flag, mem_fault_flag, invalid_cmd_flag}), "more than one flag set")

    // write exactly when no div-zero, memory-fault or invalid-command flag is set
    `SAT15_ASSERT_IMPLIES(a_write_consistent, out_valid, acc_write == !(div_zero_flag || mem_fault_flag || invalid_cmd_flag), "acc_write disagrees with flags")

    // saturation lands on a rail
    `SAT15_ASSERT_IMPLIES(a_ovf_rail, out_valid && overflow_flag, acc_result == MAX_WORD || acc_result == MIN_WORD, "overflow without saturated result")

    // an empty or draining output stage never blocks the input
    `SAT15_ASSERT_IMPLIES(a_no_false_stall, !out_valid || out_ready, in_ready, "input stalled with output free")

    // a held result stays put
    `SAT15_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(acc_result) && $stable(acc_write) && $stable(overflow_flag), "output changed under stall")

endmodule

bind saturating_15bit_alu sat15alu_checker #(
    .WORD_BITS (WORD_BITS)
) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_ready         (req.ready),
    .out_valid        (rsp.valid),
    .out_ready        (rsp.ready),
    .acc_result       (rsp.acc_result),
    .acc_write        (rsp.acc_write),
    .overflow_flag    (rsp.overflow_flag),
    .div_zero_flag    (rsp.div_zero_flag),
    .mem_fault_flag   (rsp.mem_fault_flag),
    .invalid_cmd_flag (rsp.invalid_cmd_flag)
);

`default_nettype wire

@@ test/saturating_15bit_alu_test.sv @@
module saturating_15bit_alu_test;
    import sat15alu_pkg::*;

    localparam int WORD_BITS    = WORD_BITS_DEFAULT;
    localparam int LONG_HOLD    = 300;
    localparam int END_WAIT     = 2 * (WORD_BITS + 2) + 10;
    localparam int PHASE_ITEMS  = 375;
    localparam int LIMIT_CYCLES = 200000;

    typedef logic [WORD_BITS-1:0] word_t;

    localparam word_t MAX_POS = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t MIN_NEG = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef struct packed {
        logic [FUNC_BITS-1:0] func;
        word_t                acc_value;
        word_t                memory_word;
        logic                 memory_fault;
    } alu_cmd_t;

    typedef struct packed {
        word_t acc_result;
        logic  acc_write;
        logic  overflow_flag;
        logic  div_zero_flag;
        logic  mem_fault_flag;
        logic  invalid_cmd_flag;
    } alu_res_t;

    class alu_scoreboard;
        alu_res_t    pending_results[$];
        int unsigned error_count;

        function word_t abs_word(word_t v);
            return v[WORD_BITS-1] ? (~v + 1'b1) : v;
        endfunction

        function alu_res_t compute_alu(alu_cmd_t c);
            word_t                  a;
            word_t                  b;
            word_t                  r;
            word_t                  q;
            logic [2*WORD_BITS-1:0] pa;
            logic [2*WORD_BITS-1:0] pb;
            logic [2*WORD_BITS-1:0] p;
            logic                   neg;
            logic                   same;
            alu_res_t               e;
            a = c.acc_value;
            b = c.memory_word;
            e = '0;
            e.acc_result = a;
            neg = a[WORD_BITS-1] != b[WORD_BITS-1];
            if (c.memory_fault)
            begin
                e.mem_fault_flag = 1'b1;
            end
            else if (c.func == CMD_ADD || c.func == CMD_SUB)
            begin
                r = (c.func == CMD_ADD) ? a + b : a - b;
                same = (c.func == CMD_ADD) ? !neg : neg;
                if (same && a[WORD_BITS-1] != r[WORD_BITS-1])
                begin
                    e.overflow_flag = 1'b1;
                    r = a[WORD_BITS-1] ? MIN_NEG : MAX_POS;
                end
                e.acc_result = r;
                e.acc_write = 1'b1;
            end
            else if (c.func == CMD_DIV)
            begin
                if (abs_word(b) == '0)
                begin
                    e.div_zero_flag = 1'b1;
                end
                else
                begin
                    q = abs_word(a) / abs_word(b);
                    e.acc_result = neg ? ~q + 1'b1 : q;
                    e.acc_write = 1'b1;
                end
            end
            else if (c.func == CMD_MUL)
            begin
                pa = {{WORD_BITS{1'b0}}, abs_word(a)};
                pb = {{WORD_BITS{1'b0}}, abs_word(b)};
                p = pa * pb;
                if ((neg && p > {{WORD_BITS{1'b0}}, MIN_NEG})
                    || (!neg && p > {{WORD_BITS{1'b0}}, MAX_POS}))
                begin
                    e.overflow_flag = 1'b1;
                    e.acc_result = neg ? MIN_NEG : MAX_POS;
                end
                else
                begin
                    e.acc_result = neg ? ~p[WORD_BITS-1:0] + 1'b1 : p[WORD_BITS-1:0];
                end
                e.acc_write = 1'b1;
            end
            else
            begin
                e.invalid_cmd_flag = 1'b1;
            end
            return e;
        endfunction

        function void note_cmd(alu_cmd_t c);
            pending_results.push_back(compute_alu(c));
        endfunction

        function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v)
            begin
                $display("%0t: %s expected %0h got %0h", $time, name, exp_v, act_v);
                error_count++;
            end
        endfunction

        function void check_result(alu_res_t got);
            alu_res_t exp_r;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none got %0h", $time, got);
                error_count++;
                return;
            end
            exp_r = pending_results.pop_front();
            compare_field("acc_result", 32'(exp_r.acc_result), 32'(got.acc_result));
            compare_field("acc_write", 32'(exp_r.acc_write), 32'(got.acc_write));
            compare_field("overflow_flag", 32'(exp_r.overflow_flag),
                          32'(got.overflow_flag));
            compare_field("div_zero_flag", 32'(exp_r.div_zero_flag),
                          32'(got.div_zero_flag));
            compare_field("mem_fault_flag", 32'(exp_r.mem_fault_flag),
                          32'(got.mem_fault_flag));
            compare_field("invalid_cmd_flag", 32'(exp_r.invalid_cmd_flag),
                          32'(got.invalid_cmd_flag));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned idle_pct;
    int unsigned stall_pct;
    bit          hold_request;
    int unsigned hold_left;
    int unsigned cycle_count;

    alu_scoreboard sb = new();

    sat15alu_in_if  #(.WORD_BITS(WORD_BITS)) req_if ();
    sat15alu_out_if #(.WORD_BITS(WORD_BITS)) rsp_if ();

    saturating_15bit_alu #(.WORD_BITS(WORD_BITS)) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("FAIL saturating_15bit_alu");
            $finish;
        end
    end

    // input and output monitors
    always @(posedge clk)
    begin
        if (rst_n && req_if.valid && req_if.ready)
        begin
            sb.note_cmd('{req_if.func, req_if.acc_value, req_if.memory_word,
                          req_if.memory_fault});
        end
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            sb.check_result('{rsp_if.acc_result, rsp_if.acc_write, rsp_if.overflow_flag,
                              rsp_if.div_zero_flag, rsp_if.mem_fault_flag,
                              rsp_if.invalid_cmd_flag});
        end
    end

    // receiver side, with one long hold-off in the first random phase
    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                rsp_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_cmd(input alu_cmd_t c);
        while ($urandom_range(99) < idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid        <= 1'b1;
        req_if.func         <= c.func;
        req_if.acc_value    <= c.acc_value;
        req_if.memory_word  <= c.memory_word;
        req_if.memory_fault <= c.memory_fault;
        @(posedge clk);
        while (!req_if.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic wait_all_results();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic word_t random_word();
        word_t w;
        case ($urandom_range(3))
            0: w = word_t'($urandom);
            1:
            begin
                case ($urandom_range(4))
                    0: w = '0;
                    1: w = word_t'(1);
                    2: w = MAX_POS;
                    3: w = MIN_NEG;
                    default: w = '1;
                endcase
            end
            2: w = word_t'($urandom_range(255));
            default: w = word_t'($urandom_range(100, 200));
        endcase
        if ($urandom_range(1) && w != MIN_NEG)
        begin
            w = ~w + 1'b1;
        end
        return w;
    endfunction

    function automatic alu_cmd_t random_cmd();
        alu_cmd_t c;
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 22)
            c.func = CMD_ADD;
        else if (sel < 44)
            c.func = CMD_SUB;
        else if (sel < 66)
            c.func = CMD_DIV;
        else if (sel < 88)
            c.func = CMD_MUL;
        else
            c.func = FUNC_BITS'($urandom_range(127));
        c.acc_value    = random_word();
        c.memory_word  = random_word();
        c.memory_fault = ($urandom_range(9) == 0);
        return c;
    endfunction

    initial
    begin
        int unsigned idle_sets[4];
        int unsigned stall_sets[4];
        rst_n               = 1'b0;
        idle_pct            = 0;
        stall_pct           = 0;
        hold_request        = 1'b0;
        hold_left           = 0;
        cycle_count         = 0;
        req_if.valid        = 1'b0;
        req_if.func         = '0;
        req_if.acc_value    = '0;
        req_if.memory_word  = '0;
        req_if.memory_fault = 1'b0;
        idle_sets  = '{0, 61, 0, 12};
        stall_sets = '{0, 0, 61, 12};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // saturation edges of add and sub
        send_cmd('{CMD_ADD, MAX_POS, word_t'(1), 1'b0});
        send_cmd('{CMD_ADD, MIN_NEG, '1, 1'b0});
        send_cmd('{CMD_ADD, '1, '1, 1'b0});
        send_cmd('{CMD_ADD, '0, '0, 1'b0});
        send_cmd('{CMD_SUB, MAX_POS, '1, 1'b0});
        send_cmd('{CMD_SUB, MIN_NEG, word_t'(1), 1'b0});
        send_cmd('{CMD_SUB, '0, MIN_NEG, 1'b0});
        // divide: wrap of most negative, zero divisor, truncation
        send_cmd('{CMD_DIV, MIN_NEG, word_t'(1), 1'b0});
        send_cmd('{CMD_DIV, MIN_NEG, '1, 1'b0});
        send_cmd('{CMD_DIV, MAX_POS, '0, 1'b0});
        send_cmd('{CMD_DIV, word_t'(7), -word_t'(2), 1'b0});
        send_cmd('{CMD_DIV, -word_t'(7), word_t'(2), 1'b0});
        send_cmd('{CMD_DIV, MAX_POS, MIN_NEG, 1'b0});
        // multiply: exact most negative product, saturation both ways
        send_cmd('{CMD_MUL, MIN_NEG, word_t'(1), 1'b0});
        send_cmd('{CMD_MUL, MIN_NEG, '1, 1'b0});
        send_cmd('{CMD_MUL, word_t'(128), -word_t'(128), 1'b0});
        send_cmd('{CMD_MUL, word_t'(128), word_t'(128), 1'b0});
        send_cmd('{CMD_MUL, MAX_POS, MIN_NEG, 1'b0});
        send_cmd('{CMD_MUL, -word_t'(3), word_t'(5), 1'b0});
        // invalid codes, and memory fault over divide, multiply and an invalid code
        send_cmd('{'0, MAX_POS, MAX_POS, 1'b0});
        send_cmd('{'1, MIN_NEG, MIN_NEG, 1'b0});
        send_cmd('{CMD_ADD - 1'b1, '1, '0, 1'b0});
        send_cmd('{CMD_MUL + 1'b1, '0, '1, 1'b0});
        send_cmd('{CMD_DIV, MAX_POS, '0, 1'b1});
        send_cmd('{CMD_MUL, MAX_POS, MAX_POS, 1'b1});
        send_cmd('{'1, '1, '1, 1'b1});
        wait_all_results();

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct  = idle_sets[ph];
            stall_pct = stall_sets[ph];
            if (ph == 0)
                hold_request = 1'b1;
            repeat (PHASE_ITEMS) send_cmd(random_cmd());
            wait_all_results();
        end

        repeat (END_WAIT) @(posedge clk);
        if (sb.error_count == 0 && sb.pending_results.size() == 0)
            $display("PASS saturating_15bit_alu");
        else
            $display("FAIL saturating_15bit_alu");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/sat15alu_pkg.sv
rtl/core/sat15alu_if.sv
rtl/core/sat15alu_front.sv
rtl/core/sat15alu_div_step.sv
rtl/core/sat15alu_back.sv
rtl/core/saturating_15bit_alu.sv
rtl/core/sat15alu_checker.sv
test/saturating_15bit_alu_test.sv
